FILE: design/tlre_pkg.sv
// ----------------------------------------------------------------------------
// tlre_pkg: shared types and constants for the text line ring extractor
// Request and result payloads, operation and result codes, ring sizing.
// ----------------------------------------------------------------------------
package tlre_pkg;

  // Ring sizing
  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Longest line that is returned as a line
  localparam int MAX_LINE = 63;
  localparam int IDX_W    = $clog2(MAX_LINE + 1);

  // Depth of the small queues on both sides of the engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_S  = 8'h53;

  // Request type codes on the input port
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Classified operation handed to the engine
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PUSH_OK    = 3'd0,
    KIND_PUSH_FULL  = 3'd1,
    KIND_LINE_BYTE  = 3'd2,
    KIND_NO_LINE    = 3'd3,
    KIND_TOO_LONG   = 3'd4,
    KIND_EMPTY_LINE = 3'd5
  } kind_t;

  // Input transaction
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_req_t;

  // Result transaction
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        line_byte;
    logic              last_of_line;
    logic              command_line;
    logic [FILL_W-1:0] fill_level;
  } out_res_t;

  // Classified request between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } req_t;

endpackage

FILE: design/tlre_ram.sv
// ----------------------------------------------------------------------------
// tlre_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module tlre_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tlre_front.sv
// ----------------------------------------------------------------------------
// tlre_front: request intake
// Accepts input transactions, decodes the request type and queues them.
// ----------------------------------------------------------------------------
module tlre_front
  import tlre_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  in_req_t in_data,
  output logic    req_valid,
  input  logic    req_take,
  output req_t    req
);

  req_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr;
  logic              do_rd;
  req_t              dec;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign req_valid = (cnt_r != '0);
  assign req       = q_r[rd_ptr_r];
  assign do_wr     = push && !full;
  assign do_rd     = req_take && req_valid;

  function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Classify the request type
  always_comb begin
    dec.data = in_data.data_byte;
    unique case (in_data.req_type)
      REQ_PUSH:  dec.op = OP_PUSH;
      REQ_POP:   dec.op = OP_POP;
      REQ_CLEAR: dec.op = OP_CLEAR;
      default:   dec.op = OP_NOP;
    endcase
  end

  // Hold queue entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= qptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= qptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/tlre_outq.sv
// ----------------------------------------------------------------------------
// tlre_outq: result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module tlre_outq
  import tlre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     oq_push,
  input  out_res_t oq_item,
  output logic     oq_full,
  output logic     empty,
  input  logic     pop,
  output out_res_t out_data
);

  out_res_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign oq_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_data = q_r[rd_ptr_r];
  assign do_wr    = oq_push && !oq_full;
  assign do_rd    = pop && !empty;

  function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Hold queue entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= oq_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= qptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= qptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/tlre_back.sv
// ----------------------------------------------------------------------------
// tlre_back: ring engine
// Owns the byte ring and its pointers; executes push, line pop and clear.
// ----------------------------------------------------------------------------
module tlre_back
  import tlre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_take,
  input  req_t     req,
  output logic     oq_push,
  output out_res_t oq_item,
  input  logic     oq_full
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TERM,
    ST_EMIT,
    ST_LAST
  } state_t;

  state_t            state_r,    state_nxt;
  logic [PTR_W-1:0]  rp_r,       rp_nxt;
  logic [PTR_W-1:0]  wp_r,       wp_nxt;
  logic              full_r,     full_nxt;
  logic [IDX_W-1:0]  i_r,        i_nxt;
  logic [IDX_W-1:0]  n_r,        n_nxt;
  logic [IDX_W-1:0]  j_r,        j_nxt;
  logic [FILL_W-1:0] avail_r,    avail_nxt;
  logic [FILL_W-1:0] lim_r,      lim_nxt;
  logic [FILL_W-1:0] consume_r,  consume_nxt;
  logic [FILL_W-1:0] fill_out_r, fill_out_nxt;
  logic              cmd_r,      cmd_nxt;
  logic              term_cr_r,  term_cr_nxt;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  logic [FILL_W-1:0] held;
  logic              is_term;
  logic              crlf;
  logic [FILL_W-1:0] term_cons;

  // Advance a ring pointer by k, where k never exceeds the ring depth
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0]  p,
                                               input logic [FILL_W-1:0] k);
    logic [FILL_W:0] sum;
    sum = (FILL_W + 1)'(p) + (FILL_W + 1)'(k);
    if (sum >= (FILL_W + 1)'(RING_DEPTH)) begin
      sum = sum - (FILL_W + 1)'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic is_cmd(input logic [7:0] b);
    return (b == CH_G) || (b == CH_M) || (b == CH_T) || (b == CH_S);
  endfunction

  tlre_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fill level and terminator checks
  always_comb begin
    if (full_r) begin
      held = FILL_W'(RING_DEPTH);
    end else if (wp_r >= rp_r) begin
      held = FILL_W'(wp_r - rp_r);
    end else begin
      held = FILL_W'(RING_DEPTH) + FILL_W'(wp_r) - FILL_W'(rp_r);
    end
    is_term   = (ram_rdata == CH_CR) || (ram_rdata == CH_LF);
    crlf      = term_cr_r && (avail_r > FILL_W'(n_r) + 1'b1) && (ram_rdata == CH_LF);
    term_cons = FILL_W'(n_r) + 1'b1 + FILL_W'(crlf);
  end

  // Sequence requests through the ring
  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    full_nxt     = full_r;
    i_nxt        = i_r;
    n_nxt        = n_r;
    j_nxt        = j_r;
    avail_nxt    = avail_r;
    lim_nxt      = lim_r;
    consume_nxt  = consume_r;
    fill_out_nxt = fill_out_r;
    cmd_nxt      = cmd_r;
    term_cr_nxt  = term_cr_r;

    req_take     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wp_r;
    ram_wdata    = req.data;
    ram_re       = 1'b0;
    ram_raddr    = rp_r;

    oq_push              = 1'b0;
    oq_item.kind         = KIND_PUSH_OK;
    oq_item.line_byte    = '0;
    oq_item.last_of_line = 1'b0;
    oq_item.command_line = 1'b0;
    oq_item.fill_level   = held;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid && !oq_full) begin
          req_take = 1'b1;
          unique case (req.op)
            OP_PUSH: begin
              oq_push = 1'b1;
              if (full_r) begin
                oq_item.kind = KIND_PUSH_FULL;
              end else begin
                ram_we             = 1'b1;
                wp_nxt             = ptr_adv(wp_r, FILL_W'(1));
                full_nxt           = (wp_nxt == rp_r);
                oq_item.fill_level = held + 1'b1;
              end
            end
            OP_POP: begin
              if (held == '0) begin
                oq_push      = 1'b1;
                oq_item.kind = KIND_NO_LINE;
              end else begin
                ram_re    = 1'b1;
                avail_nxt = held;
                if (32'(held) > 32'(MAX_LINE)) begin
                  lim_nxt = FILL_W'(MAX_LINE + 1);
                end else begin
                  lim_nxt = held;
                end
                i_nxt     = '0;
                state_nxt = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              rp_nxt   = '0;
              wp_nxt   = '0;
              full_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // Look for the first CR or LF, one byte per cycle while the result queue has room
      ST_SCAN: begin
        if (!oq_full) begin
          if (i_r == '0) begin
            cmd_nxt = is_cmd(ram_rdata);
          end
          if (is_term) begin
            n_nxt       = i_r;
            term_cr_nxt = (ram_rdata == CH_CR);
            ram_re      = 1'b1;
            ram_raddr   = ptr_adv(rp_r, FILL_W'(i_r) + 1'b1);
            state_nxt   = ST_TERM;
          end else if (FILL_W'(i_r) + 1'b1 == lim_r) begin
            oq_push   = 1'b1;
            state_nxt = ST_IDLE;
            if (32'(avail_r) > 32'(MAX_LINE)) begin
              oq_item.kind       = KIND_TOO_LONG;
              oq_item.fill_level = avail_r - FILL_W'(MAX_LINE);
              rp_nxt             = ptr_adv(rp_r, FILL_W'(MAX_LINE));
              full_nxt           = 1'b0;
            end else begin
              oq_item.kind       = KIND_NO_LINE;
              oq_item.fill_level = avail_r;
            end
          end else begin
            i_nxt     = i_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = ptr_adv(rp_r, FILL_W'(i_r) + 1'b1);
          end
        end
      end

      // Check for LF after CR, then settle the consumed length
      ST_TERM: begin
        if (!oq_full) begin
          if (n_r == '0) begin
            oq_push            = 1'b1;
            oq_item.kind       = KIND_EMPTY_LINE;
            oq_item.fill_level = avail_r - term_cons;
            rp_nxt             = ptr_adv(rp_r, term_cons);
            full_nxt           = 1'b0;
            state_nxt          = ST_IDLE;
          end else begin
            consume_nxt  = term_cons;
            fill_out_nxt = avail_r - term_cons;
            ram_re       = 1'b1;
            ram_raddr    = rp_r;
            j_nxt        = '0;
            state_nxt    = ST_EMIT;
          end
        end
      end

      // Replay the line bytes from the ring
      ST_EMIT: begin
        if (!oq_full) begin
          oq_push              = 1'b1;
          oq_item.kind         = KIND_LINE_BYTE;
          oq_item.line_byte    = ram_rdata;
          oq_item.command_line = cmd_r;
          oq_item.fill_level   = fill_out_r;
          if (j_r == n_r - 1'b1) begin
            state_nxt = ST_LAST;
          end else begin
            j_nxt     = j_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = ptr_adv(rp_r, FILL_W'(j_r) + 1'b1);
          end
        end
      end

      // Append LF and drop the consumed bytes
      ST_LAST: begin
        if (!oq_full) begin
          oq_push              = 1'b1;
          oq_item.kind         = KIND_LINE_BYTE;
          oq_item.line_byte    = CH_LF;
          oq_item.last_of_line = 1'b1;
          oq_item.command_line = cmd_r;
          oq_item.fill_level   = fill_out_r;
          rp_nxt               = ptr_adv(rp_r, consume_r);
          full_nxt             = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, pointers and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      full_r  <= full_nxt;
    end
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    avail_r    <= avail_nxt;
    lim_r      <= lim_nxt;
    consume_r  <= consume_nxt;
    fill_out_r <= fill_out_nxt;
    cmd_r      <= cmd_nxt;
    term_cr_r  <= term_cr_nxt;
  end

`ifndef SYNTHESIS
  // A full ring always has coinciding pointers
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wp_r == rp_r))
    else $error("full flag set with distinct pointers");

  // Replay index stays inside the found line
  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (j_r < n_r))
    else $error("line replay index past line length");

  // The ring stays untouched while a pop is in progress
  a_pop_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(wp_r))
    else $error("write pointer moved during a line pop");
`endif

endmodule

FILE: design/text_line_ring_extractor.sv
// ----------------------------------------------------------------------------
// text_line_ring_extractor: line-splitting byte ring buffer
// Front queue classifies requests, the ring engine runs them, results queue.
// ----------------------------------------------------------------------------
// Result path: a push or empty-ring pop result shows on the result ports once the
//   request has passed the front queue and the engine has written the result queue.
// Throughput: pushes sustain one per cycle while the result queue has room; a
//   line pop scans and then replays the line through the single ring read port,
//   one byte per cycle each pass while the result queue has room.
// Reset: synchronous, clears pointers, full flag and queues; the ring memory
//   is not swept, so the block is ready in the first cycle after reset.
module text_line_ring_extractor
  import tlre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_req_t  in_data,
  output logic     empty,
  input  logic     pop,
  output out_res_t out_data
);

  logic     req_valid;
  logic     req_take;
  req_t     req;
  logic     oq_push;
  out_res_t oq_item;
  logic     oq_full;

  tlre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req       (req)
  );

  tlre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req       (req),
    .oq_push   (oq_push),
    .oq_item   (oq_item),
    .oq_full   (oq_full)
  );

  tlre_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .oq_push  (oq_push),
    .oq_item  (oq_item),
    .oq_full  (oq_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
